@@ hdl/smf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the MIDI file stream parser
// Parse phases, result kinds, error codes and the result record type.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam logic [31:0] HDR_ID_RESET = 32'h4D546864;
  localparam logic [31:0] TRK_ID_RESET = 32'h4D54726B;
  localparam int VLQ_MAX_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR_ID, PH_HDR_SIZE, PH_HDR_FMT, PH_HDR_TRK, PH_HDR_DIV,
    PH_TRK_ID, PH_TRK_LEN, PH_DELTA, PH_STATUS, PH_META_TYPE, PH_LEN,
    PH_PAYLOAD, PH_P1, PH_P2
  } phase_t;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_TRACK   = 3'd1;
  localparam logic [2:0] KIND_EVENT   = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [1:0] ERR_HDR_ID   = 2'd0;
  localparam logic [1:0] ERR_TIMECODE = 2'd1;
  localparam logic [1:0] ERR_TRK_ID   = 2'd2;
  localparam logic [1:0] ERR_STATUS   = 2'd3;

  localparam logic [0:0] REG_HDR_ID = 1'b0;
  localparam logic [0:0] REG_TRK_ID = 1'b1;

  // one input request after the front stage
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [27:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_param;
    logic [7:0]  second_param;
    logic [31:0] length_value;
    logic [7:0]  payload_byte;
    logic        track_done;
    logic [1:0]  error_code;
    logic [15:0] header_format;
    logic [15:0] header_tracks;
    logic [14:0] header_division;
  } result_t;

endpackage

@@ hdl/smf_byte_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_byte_queue: short FIFO between the byte intake and the parser
// Accepts a request whenever not full; full depth keeps rate with stall.
// ----------------------------------------------------------------------------
module smf_byte_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  smf_pkg::byte_req_t  in_req,
  output logic                out_valid,
  input  logic                out_take,
  output smf_pkg::byte_req_t  out_req
);
  localparam int D = smf_pkg::QUEUE_DEPTH;
  localparam int AW = $clog2(D);

  smf_pkg::byte_req_t mem [D];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_stall  = (count == (AW+1)'(D));
  assign out_valid = (count != '0);
  assign out_req   = mem[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && out_take;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(D-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(D-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ hdl/smf_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_parser_core: per-byte parse state machine with registered result
// Takes one byte per cycle while its result register is free or drains.
// ----------------------------------------------------------------------------
module smf_parser_core #(
  parameter int VLQ_MAX_BYTES = smf_pkg::VLQ_MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        hdr_id,
  input  logic [31:0]        trk_id,
  input  logic               in_valid,
  output logic               in_take,
  input  smf_pkg::byte_req_t in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output smf_pkg::result_t   out_res
);
  smf_pkg::phase_t phase, phase_next, ph_eff;
  logic [2:0]  cnt, cnt_next, cnt_eff, cnt_inc;
  logic [31:0] acc, acc_next, acc_eff;
  logic [27:0] pdelta, pdelta_next;
  logic [7:0]  pstatus, pstatus_next;
  logic [7:0]  pfirst, pfirst_next;
  logic [27:0] prem, prem_next, prem_dec;
  logic [31:0] tlen, tlen_next, tlen_eff;
  logic [31:0] tused, tused_next, tused_eff;
  logic [15:0] trem, trem_next, trem_eff, trem_dec;
  logic [15:0] sfmt, sfmt_next, strk, strk_next;
  logic        fresh;
  logic [7:0]  b;
  logic [31:0] fix_acc, vlq_acc;
  logic        emit;
  smf_pkg::result_t res;

  assign b       = in_req.data;
  assign fresh   = in_req.start;
  assign in_take = in_valid && (!out_valid || !out_stall);
  assign ph_eff  = fresh ? smf_pkg::PH_HDR_ID : phase;
  assign cnt_eff = fresh ? 3'd0 : cnt;
  assign acc_eff = fresh ? 32'd0 : acc;
  assign tlen_eff = fresh ? 32'd0 : tlen;
  assign trem_eff = fresh ? 16'd0 : trem;
  assign cnt_inc = cnt_eff + 3'd1;
  assign fix_acc = {acc_eff[23:0], b};
  assign vlq_acc = {acc_eff[24:0], b[6:0]};
  assign prem_dec = prem - 28'd1;
  assign trem_dec = trem_eff - 16'd1;

  // next parse state and result
  always_comb begin
    phase_next  = ph_eff;
    cnt_next    = cnt_eff;
    acc_next    = acc_eff;
    pdelta_next = fresh ? 28'd0 : pdelta;
    pstatus_next = fresh ? 8'd0 : pstatus;
    pfirst_next = fresh ? 8'd0 : pfirst;
    prem_next   = fresh ? 28'd0 : prem;
    tlen_next   = tlen_eff;
    tused_eff   = fresh ? 32'd0 : tused;
    trem_next   = trem_eff;
    sfmt_next   = fresh ? 16'd0 : sfmt;
    strk_next   = fresh ? 16'd0 : strk;
    res         = '0;
    emit        = 1'b0;
    if (ph_eff >= smf_pkg::PH_DELTA && tused_eff != 32'hFFFF_FFFF) begin
      tused_eff = tused_eff + 32'd1;
    end
    tused_next = tused_eff;
    unique case (ph_eff)
      smf_pkg::PH_IDLE: ;
      smf_pkg::PH_HDR_ID, smf_pkg::PH_HDR_SIZE, smf_pkg::PH_TRK_ID: begin
        acc_next = fix_acc;
        cnt_next = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          acc_next = '0;
          cnt_next = '0;
          if (ph_eff == smf_pkg::PH_HDR_ID) begin
            if (fix_acc != hdr_id) begin
              emit = 1'b1; res.kind = smf_pkg::KIND_ERROR;
              res.error_code = smf_pkg::ERR_HDR_ID;
              phase_next = smf_pkg::PH_IDLE;
            end else phase_next = smf_pkg::PH_HDR_SIZE;
          end else if (ph_eff == smf_pkg::PH_HDR_SIZE) begin
            phase_next = smf_pkg::PH_HDR_FMT;
          end else if (fix_acc != trk_id) begin
            emit = 1'b1; res.kind = smf_pkg::KIND_ERROR;
            res.error_code = smf_pkg::ERR_TRK_ID;
            phase_next = smf_pkg::PH_IDLE;
          end else phase_next = smf_pkg::PH_TRK_LEN;
        end
      end
      smf_pkg::PH_HDR_FMT, smf_pkg::PH_HDR_TRK, smf_pkg::PH_HDR_DIV: begin
        acc_next = fix_acc;
        cnt_next = cnt_inc;
        if (cnt_inc >= 3'd2) begin
          acc_next = '0;
          cnt_next = '0;
          if (ph_eff == smf_pkg::PH_HDR_FMT) begin
            sfmt_next = fix_acc[15:0]; phase_next = smf_pkg::PH_HDR_TRK;
          end else if (ph_eff == smf_pkg::PH_HDR_TRK) begin
            strk_next = fix_acc[15:0]; phase_next = smf_pkg::PH_HDR_DIV;
          end else if (fix_acc[15]) begin
            emit = 1'b1; res.kind = smf_pkg::KIND_ERROR;
            res.error_code = smf_pkg::ERR_TIMECODE;
            phase_next = smf_pkg::PH_IDLE;
          end else begin
            emit = 1'b1; res.kind = smf_pkg::KIND_HEADER;
            res.header_format = sfmt_next;
            res.header_tracks = strk_next;
            res.header_division = fix_acc[14:0];
            trem_next = strk_next;
            phase_next = (strk_next == 16'd0) ? smf_pkg::PH_IDLE : smf_pkg::PH_TRK_ID;
          end
        end
      end
      smf_pkg::PH_TRK_LEN: begin
        acc_next = fix_acc;
        cnt_next = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          acc_next = '0; cnt_next = '0;
          tlen_next = fix_acc;
          tused_next = '0;
          emit = 1'b1; res.kind = smf_pkg::KIND_TRACK;
          res.length_value = fix_acc;
          if (fix_acc == 32'd0) begin
            res.track_done = 1'b1; trem_next = trem_dec;
            phase_next = (trem_dec == 16'd0) ? smf_pkg::PH_IDLE : smf_pkg::PH_TRK_ID;
          end else phase_next = smf_pkg::PH_DELTA;
        end
      end
      smf_pkg::PH_DELTA, smf_pkg::PH_LEN: begin
        acc_next = vlq_acc;
        cnt_next = cnt_inc;
        if (!b[7] || cnt_inc >= 3'(VLQ_MAX_BYTES)) begin
          acc_next = '0; cnt_next = '0;
          if (ph_eff == smf_pkg::PH_DELTA) begin
            pdelta_next = b[7] ? 28'd0 : vlq_acc[27:0];
            phase_next = smf_pkg::PH_STATUS;
          end else begin
            prem_next = b[7] ? 28'd0 : vlq_acc[27:0];
            emit = 1'b1; res.kind = smf_pkg::KIND_EVENT;
            res.length_value = {4'd0, prem_next};
            if (prem_next == 28'd0) begin
              if (tused_eff >= tlen_eff) begin
                res.track_done = 1'b1; trem_next = trem_dec;
                phase_next = (trem_dec == 16'd0) ? smf_pkg::PH_IDLE : smf_pkg::PH_TRK_ID;
              end else phase_next = smf_pkg::PH_DELTA;
            end else phase_next = smf_pkg::PH_PAYLOAD;
          end
        end
      end
      smf_pkg::PH_STATUS: begin
        pstatus_next = b;
        if (b == 8'hFF) phase_next = smf_pkg::PH_META_TYPE;
        else if (b == 8'hF0 || b == 8'hF7) begin
          pfirst_next = 8'd0; phase_next = smf_pkg::PH_LEN;
        end else if (b >= 8'h80 && b <= 8'hEF) phase_next = smf_pkg::PH_P1;
        else begin
          emit = 1'b1; res.kind = smf_pkg::KIND_ERROR;
          res.error_code = smf_pkg::ERR_STATUS;
          phase_next = smf_pkg::PH_IDLE;
        end
      end
      smf_pkg::PH_META_TYPE: begin
        pfirst_next = b; phase_next = smf_pkg::PH_LEN;
      end
      smf_pkg::PH_PAYLOAD: begin
        emit = 1'b1; res.kind = smf_pkg::KIND_PAYLOAD;
        res.payload_byte = b;
        prem_next = prem_dec;
        if (prem_dec == 28'd0) begin
          if (tused_eff >= tlen_eff) begin
            res.track_done = 1'b1; trem_next = trem_dec;
            phase_next = (trem_dec == 16'd0) ? smf_pkg::PH_IDLE : smf_pkg::PH_TRK_ID;
          end else phase_next = smf_pkg::PH_DELTA;
        end
      end
      smf_pkg::PH_P1, smf_pkg::PH_P2: begin
        if (ph_eff == smf_pkg::PH_P1) pfirst_next = b;
        if (ph_eff == smf_pkg::PH_P2 || pstatus[7:4] == 4'hC || pstatus[7:4] == 4'hD) begin
          emit = 1'b1; res.kind = smf_pkg::KIND_EVENT;
          res.second_param = (ph_eff == smf_pkg::PH_P2) ? b : 8'd0;
          if (tused_eff >= tlen_eff) begin
            res.track_done = 1'b1; trem_next = trem_dec;
            phase_next = (trem_dec == 16'd0) ? smf_pkg::PH_IDLE : smf_pkg::PH_TRK_ID;
          end else phase_next = smf_pkg::PH_DELTA;
        end else phase_next = smf_pkg::PH_P2;
      end
      default: phase_next = smf_pkg::PH_IDLE;
    endcase
    if (res.kind == smf_pkg::KIND_EVENT) begin
      res.delta_time  = pdelta;
      res.status_byte = pstatus;
      res.first_param = pfirst_next;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= smf_pkg::PH_IDLE;
      cnt <= '0; acc <= '0; pdelta <= '0; pstatus <= '0; pfirst <= '0;
      prem <= '0; tlen <= '0; tused <= '0; trem <= '0; sfmt <= '0; strk <= '0;
    end else if (in_take) begin
      phase <= phase_next;
      cnt <= cnt_next; acc <= acc_next; pdelta <= pdelta_next;
      pstatus <= pstatus_next; pfirst <= pfirst_next; prem <= prem_next;
      tlen <= tlen_next; tused <= tused_next; trem <= trem_next;
      sfmt <= sfmt_next; strk <= strk_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_take) out_valid <= emit;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) out_res <= res;
  end
endmodule

@@ hdl/midi_file_stream_parser_top.sv @@
`timescale 1ns / 1ps
// A byte's result passes through a queue slot, then the parser result register,
// before it is on the outputs. Throughput: one byte per cycle, set by the
// single parse state update per byte; a stalled result holds the parser and the
// two-entry queue then fills. Synchronous reset returns the parser to waiting
// for a file start and the ID registers to MThd / MTrk.
// ----------------------------------------------------------------------------
// midi_file_stream_parser_top: Standard MIDI File byte stream parser
// Byte intake queue, parse core and APB register block.
// ----------------------------------------------------------------------------
module midi_file_stream_parser_top #(
  parameter int VLQ_MAX_BYTES = smf_pkg::VLQ_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [27:0] delta_time,
  output logic [7:0]  status_byte,
  output logic [7:0]  first_param,
  output logic [7:0]  second_param,
  output logic [31:0] length_value,
  output logic [7:0]  payload_byte,
  output logic        track_done,
  output logic [1:0]  error_code,
  output logic [15:0] header_format,
  output logic [15:0] header_tracks,
  output logic [14:0] header_division
);
  logic [31:0] hdr_id, trk_id;
  smf_pkg::byte_req_t in_req, q_req;
  logic q_valid, q_take;
  smf_pkg::result_t r;

  // register block
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_id <= smf_pkg::HDR_ID_RESET;
      trk_id <= smf_pkg::TRK_ID_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[2] == smf_pkg::REG_HDR_ID) hdr_id <= pwdata;
      else trk_id <= pwdata;
    end
  end
  assign prdata = (paddr[1:0] != 2'd0) ? 32'd0 :
                  (paddr[2] == smf_pkg::REG_TRK_ID) ? trk_id : hdr_id;

  assign in_req.data  = file_byte;
  assign in_req.start = file_start;

  smf_byte_queue u_queue (
    .clk, .rst, .in_valid, .in_stall, .in_req,
    .out_valid(q_valid), .out_take(q_take), .out_req(q_req)
  );

  smf_parser_core #(.VLQ_MAX_BYTES(VLQ_MAX_BYTES)) u_core (
    .clk, .rst, .hdr_id, .trk_id,
    .in_valid(q_valid), .in_take(q_take), .in_req(q_req),
    .out_valid, .out_stall, .out_res(r)
  );

  assign kind = r.kind;
  assign delta_time = r.delta_time;
  assign status_byte = r.status_byte;
  assign first_param = r.first_param;
  assign second_param = r.second_param;
  assign length_value = r.length_value;
  assign payload_byte = r.payload_byte;
  assign track_done = r.track_done;
  assign error_code = r.error_code;
  assign header_format = r.header_format;
  assign header_tracks = r.header_tracks;
  assign header_division = r.header_division;
endmodule
